/* hw/rtl/contiguous_page_allocator_defines.svh */
// Assertion macros for the contiguous page allocator.
// Expects clk_i and rst_ni in the scope that uses them.
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_DEFINES_SVH

// check cons in the same cycle as ante
`define CPA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("page allocator check failed");

// check cons in the cycle after ante
`define CPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("page allocator check failed");

`endif

/* hw/rtl/cpa_pkg.sv */
// Shared types and constants for the contiguous page allocator.
// No dependencies.
package cpa_pkg;

  localparam int unsigned NUM_PAGES_DEF = 256;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic       vld;
    logic       ok;
    logic [7:0] first_page;
  } cpa_res_t;

endpackage

/* hw/rtl/cpa_mark_mem.sv */
// Single-bit page mark memory, one write port and one registered read port.
// Depends on cpa_pkg.
module cpa_mark_mem import cpa_pkg::*; #(
  parameter int unsigned NUM_PAGES = NUM_PAGES_DEF,
  localparam int unsigned AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);

  logic mem_q [NUM_PAGES];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/cpa_ctrl.sv */
// Sequencer for the page allocator: clearing pass, first-fit scan, mark and free sweeps.
// Depends on cpa_pkg; drives the mark memory ports.
module cpa_ctrl import cpa_pkg::*; #(
  parameter int unsigned NUM_PAGES = NUM_PAGES_DEF,
  localparam int unsigned AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1,
  localparam int unsigned PW = ((AW + 1) > 10) ? (AW + 1) : 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_vld_i,
  input  logic          req_type_i,
  input  logic [8:0]    page_count_i,
  input  logic [7:0]    start_page_i,
  output logic          busy_o,
  input  logic          res_ready_i,
  output cpa_res_t      res_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output logic          mem_wdata_o,
  output logic [AW-1:0] mem_raddr_o,
  input  logic          mem_rdata_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_DONE
  } state_e;

  localparam logic [PW-1:0] NP   = PW'(NUM_PAGES);
  localparam logic [PW-1:0] LAST = PW'(NUM_PAGES - 1);

  state_e        state_q, state_d;
  logic [PW-1:0] p_q, p_d;
  logic [PW-1:0] end_q, end_d;
  logic [PW-1:0] need_q, need_d;
  logic [PW-1:0] run_q, run_d;
  logic [PW-1:0] iss_q, iss_d;
  logic [AW-1:0] chk_q, chk_d;
  logic          chk_vld_q, chk_vld_d;
  logic          cnt_zero_q, cnt_zero_d;
  logic          wval_q, wval_d;
  logic          ok_q, ok_d;
  logic [7:0]    first_q, first_d;

  logic [PW-1:0] need_in;
  logic [PW-1:0] free_sum;
  logic [PW-1:0] run_inc;
  logic [PW-1:0] run_start;
  logic          iss_live;
  logic          mark_live;

  assign need_in   = (page_count_i == 9'd0) ? PW'(1) : PW'(page_count_i);
  assign free_sum  = PW'(start_page_i) + PW'(page_count_i);
  assign run_inc   = run_q + PW'(1);
  assign run_start = PW'(chk_q) + PW'(1) - need_q;
  assign iss_live  = (iss_q < NP);
  assign mark_live = (p_q < end_q);

  always_comb begin
    state_d    = state_q;
    p_d        = p_q;
    end_d      = end_q;
    need_d     = need_q;
    run_d      = run_q;
    iss_d      = iss_q;
    chk_d      = chk_q;
    chk_vld_d  = 1'b0;
    cnt_zero_d = cnt_zero_q;
    wval_d     = wval_q;
    ok_d       = ok_q;
    first_d    = first_q;
    case (state_q)
      ST_CLEAR: begin
        p_d = p_q + PW'(1);
        if (p_q == LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_vld_i) begin
          first_d = 8'd0;
          if (req_type_i == REQ_FREE) begin
            p_d     = PW'(start_page_i);
            end_d   = (free_sum > NP) ? NP : free_sum;
            wval_d  = 1'b0;
            ok_d    = 1'b1;
            state_d = ST_MARK;
          end else begin
            ok_d       = 1'b0;
            need_d     = need_in;
            cnt_zero_d = (page_count_i == 9'd0);
            run_d      = '0;
            iss_d      = '0;
            if (need_in > NP) begin
              state_d = ST_DONE;
            end else begin
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (iss_live) begin
          iss_d = iss_q + PW'(1);
        end
        chk_vld_d = iss_live;
        chk_d     = iss_q[AW-1:0];
        if (chk_vld_q) begin
          if (!mem_rdata_i && (run_inc >= need_q)) begin
            ok_d      = 1'b1;
            first_d   = run_start[7:0];
            chk_vld_d = 1'b0;
            if (cnt_zero_q) begin
              state_d = ST_DONE;
            end else begin
              p_d     = run_start;
              end_d   = run_start + need_q;
              wval_d  = 1'b1;
              state_d = ST_MARK;
            end
          end else begin
            run_d = mem_rdata_i ? '0 : run_inc;
            if (PW'(chk_q) == LAST) begin
              ok_d      = 1'b0;
              first_d   = 8'd0;
              chk_vld_d = 1'b0;
              state_d   = ST_DONE;
            end
          end
        end
      end
      ST_MARK: begin
        if (mark_live) begin
          p_d = p_q + PW'(1);
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      p_q        <= '0;
      end_q      <= '0;
      need_q     <= '0;
      run_q      <= '0;
      iss_q      <= '0;
      chk_q      <= '0;
      chk_vld_q  <= 1'b0;
      cnt_zero_q <= 1'b0;
      wval_q     <= 1'b0;
      ok_q       <= 1'b0;
      first_q    <= 8'd0;
    end else begin
      state_q    <= state_d;
      p_q        <= p_d;
      end_q      <= end_d;
      need_q     <= need_d;
      run_q      <= run_d;
      iss_q      <= iss_d;
      chk_q      <= chk_d;
      chk_vld_q  <= chk_vld_d;
      cnt_zero_q <= cnt_zero_d;
      wval_q     <= wval_d;
      ok_q       <= ok_d;
      first_q    <= first_d;
    end
  end

  assign busy_o           = (state_q != ST_IDLE);
  assign res_o.vld        = (state_q == ST_DONE);
  assign res_o.ok         = ok_q;
  assign res_o.first_page = first_q;

  assign mem_we_o    = (state_q == ST_CLEAR) || ((state_q == ST_MARK) && mark_live);
  assign mem_waddr_o = p_q[AW-1:0];
  assign mem_wdata_o = (state_q == ST_MARK) ? wval_q : 1'b0;
  assign mem_raddr_o = iss_live ? iss_q[AW-1:0] : '0;

endmodule

/* hw/rtl/contiguous_page_allocator.sv */
// Top level of the contiguous page allocator: sequencer, mark memory, result register.
// Reset clears control state, then a clearing pass frees every page.
// Allocate: first-fit scan, then marking of the found run (none for a zero count), then the
// result register; a count above NUM_PAGES fails unscanned. Free: clears marks, count clipped.
// One request at a time; the next is taken the cycle after its result is loaded.
`include "contiguous_page_allocator_defines.svh"

module contiguous_page_allocator import cpa_pkg::*; #(
  parameter int unsigned NUM_PAGES = NUM_PAGES_DEF,
  localparam int unsigned AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic [8:0] page_count_i,
  input  logic [7:0] start_page_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       ok_o,
  output logic [7:0] first_page_o
);

  cpa_res_t      res;
  logic          busy;
  logic          res_ready;
  logic          in_beat;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic          mem_rdata;

  logic          out_valid_q;
  logic          ok_q;
  logic [7:0]    first_q;

  assign in_stall_o = busy;
  assign in_beat    = in_valid_i && !busy;
  assign res_ready  = !out_valid_q || !out_stall_i;

  cpa_ctrl #(
    .NUM_PAGES(NUM_PAGES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_vld_i   (in_beat),
    .req_type_i  (req_type_i),
    .page_count_i(page_count_i),
    .start_page_i(start_page_i),
    .busy_o      (busy),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  cpa_mark_mem #(
    .NUM_PAGES(NUM_PAGES)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.vld && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.vld && res_ready) begin
      ok_q    <= res.ok;
      first_q <= res.first_page;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = ok_q;
  assign first_page_o = first_q;

  `CPA_ASSERT_NEXT(a_busy_after_beat, in_beat, in_stall_o)
  `CPA_ASSERT_NEXT(a_result_loaded, res.vld && res_ready, out_valid_o)
  `CPA_ASSERT_SAME(a_fail_page_zero, out_valid_o && !ok_o, first_page_o == 8'd0)
  `CPA_ASSERT_SAME(a_write_when_busy, mem_we, in_stall_o)

endmodule
